// ===== hdl/ebc_pkg.sv =====
// Package for the eight-bit CPU subset unit: sizes, action codes, opcodes,
// datapath select codes and the command/status structs. No dependencies.
package ebc_pkg;

  localparam int MemDepth = 4096;
  localparam int MemAw    = $clog2(MemDepth);

  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_LOAD  = 2'd2;
  localparam logic [1:0] ACT_EXEC  = 2'd3;

  // addressing modes
  localparam logic [3:0] M_IMM  = 4'd0;
  localparam logic [3:0] M_ZP   = 4'd1;
  localparam logic [3:0] M_ZPX  = 4'd2;
  localparam logic [3:0] M_ABS  = 4'd3;
  localparam logic [3:0] M_ABSX = 4'd4;
  localparam logic [3:0] M_ABSY = 4'd5;
  localparam logic [3:0] M_INDX = 4'd6;
  localparam logic [3:0] M_INDY = 4'd7;
  localparam logic [3:0] M_ACC  = 4'd8;
  localparam logic [3:0] M_REL  = 4'd9;

  // operation kinds
  localparam logic [2:0] K_ADC = 3'd0;
  localparam logic [2:0] K_AND = 3'd1;
  localparam logic [2:0] K_ASL = 3'd2;
  localparam logic [2:0] K_BCC = 3'd3;
  localparam logic [2:0] K_BCS = 3'd4;
  localparam logic [2:0] K_BEQ = 3'd5;
  localparam logic [2:0] K_BIT = 3'd6;

  localparam logic [3:0] FLAG_C = 4'b0001;
  localparam logic [3:0] FLAG_Z = 4'b0010;
  localparam logic [3:0] FLAG_V = 4'b0100;
  localparam logic [3:0] FLAG_N = 4'b1000;

  typedef struct packed {
    logic       ok;
    logic [2:0] kind;
    logic [3:0] mode;
    logic [2:0] cyc;
  } decode_t;

  function automatic decode_t decode_op(input logic [7:0] op);
    decode_t d;
    d = '{ok: 1'b1, kind: K_ADC, mode: M_IMM, cyc: 3'd2};
    case (op)
      8'h69: d = '{1'b1, K_ADC, M_IMM,  3'd2};
      8'h65: d = '{1'b1, K_ADC, M_ZP,   3'd3};
      8'h75: d = '{1'b1, K_ADC, M_ZPX,  3'd4};
      8'h6D: d = '{1'b1, K_ADC, M_ABS,  3'd4};
      8'h7D: d = '{1'b1, K_ADC, M_ABSX, 3'd4};
      8'h79: d = '{1'b1, K_ADC, M_ABSY, 3'd4};
      8'h61: d = '{1'b1, K_ADC, M_INDX, 3'd6};
      8'h71: d = '{1'b1, K_ADC, M_INDY, 3'd5};
      8'h29: d = '{1'b1, K_AND, M_IMM,  3'd2};
      8'h25: d = '{1'b1, K_AND, M_ZP,   3'd3};
      8'h35: d = '{1'b1, K_AND, M_ZPX,  3'd4};
      8'h2D: d = '{1'b1, K_AND, M_ABS,  3'd4};
      8'h3D: d = '{1'b1, K_AND, M_ABSX, 3'd4};
      8'h39: d = '{1'b1, K_AND, M_ABSY, 3'd4};
      8'h21: d = '{1'b1, K_AND, M_INDX, 3'd6};
      8'h31: d = '{1'b1, K_AND, M_INDY, 3'd5};
      8'h0A: d = '{1'b1, K_ASL, M_ACC,  3'd2};
      8'h06: d = '{1'b1, K_ASL, M_ZP,   3'd5};
      8'h16: d = '{1'b1, K_ASL, M_ZPX,  3'd6};
      8'h0E: d = '{1'b1, K_ASL, M_ABS,  3'd6};
      8'h1E: d = '{1'b1, K_ASL, M_ABSX, 3'd7};
      8'h90: d = '{1'b1, K_BCC, M_REL,  3'd2};
      8'hB0: d = '{1'b1, K_BCS, M_REL,  3'd2};
      8'hF0: d = '{1'b1, K_BEQ, M_REL,  3'd2};
      8'h24: d = '{1'b1, K_BIT, M_ZP,   3'd3};
      8'h2C: d = '{1'b1, K_BIT, M_ABS,  3'd4};
      default: d.ok = 1'b0;
    endcase
    return d;
  endfunction

  // datapath memory address sources
  localparam logic [2:0] AS_PC   = 3'd0;
  localparam logic [2:0] AS_IN   = 3'd1;
  localparam logic [2:0] AS_EA   = 3'd2;
  localparam logic [2:0] AS_ZP   = 3'd3;
  localparam logic [2:0] AS_ZP1  = 3'd4;
  localparam logic [2:0] AS_CLR  = 3'd5;

  // datapath latch targets for the byte just read
  localparam logic [2:0] LT_NONE = 3'd0;
  localparam logic [2:0] LT_OP   = 3'd1;
  localparam logic [2:0] LT_LO   = 3'd2;
  localparam logic [2:0] LT_HI   = 3'd3;
  localparam logic [2:0] LT_OPND = 3'd4;
  localparam logic [2:0] LT_RD   = 3'd5;

  typedef struct packed {
    logic       mem_re;
    logic       mem_we;     // write input data (or clear/ASL result)
    logic [2:0] addr_sel;
    logic [2:0] latch;      // where the byte arriving this cycle goes
    logic       pc_inc;     // advance working PC
    logic       take_item;  // register input fields
    logic       do_load;
    logic       do_exec;    // commit the instruction result
    logic       do_unsup;
    logic       clr_out;    // zero read_data/cycles/unsupported
    logic       wr_asl;     // memory write data is the shift result
    logic       ea_zp;      // EA := arriving byte (+ X for zp,X)
    logic       ea_abs;     // EA := {hi,lo} + index
    logic       ea_rel;     // EA := branch target
    logic       ea_imm;     // EA := PC
  } cmd_t;

  typedef struct packed {
    logic [1:0] action;
    decode_t    dec;
    logic       clr_done;
  } stat_t;

endpackage

// ===== hdl/ebc_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
module ebc_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    if (re) rdata <= mem[addr];
  end
endmodule

// ===== hdl/ebc_datapath.sv =====
// Datapath: registers, address generation, ALU and the main memory.
// Depends on ebc_pkg and ebc_ram.
module ebc_datapath (
  input  logic              clk,
  input  logic              rst,
  input  ebc_pkg::cmd_t     cmd,
  input  logic [1:0]        action,
  input  logic [15:0]       address,
  input  logic [7:0]        data,
  input  logic [7:0]        load_x,
  input  logic [7:0]        load_y,
  input  logic [3:0]        load_flags,
  input  logic [2:0]        cur_kind,
  input  logic [3:0]        cur_mode,
  input  logic [2:0]        cur_cyc,
  output logic [1:0]        cur_action,
  output logic [7:0]        opcode,
  output logic [15:0]       program_counter,
  output logic [7:0]        accumulator,
  output logic [3:0]        flags,
  output logic [7:0]        read_data,
  output logic [2:0]        cycles_taken,
  output logic              unsupported,
  output logic              clr_done
);
  import ebc_pkg::*;

  logic [7:0]  acc, xr, yr;
  logic [15:0] pc;
  logic [3:0]  flg;
  logic [1:0]  in_act;
  logic [15:0] in_addr;
  logic [7:0]  in_data, in_x, in_y;
  logic [3:0]  in_flags;
  logic [15:0] wpc, ea;
  logic [7:0]  lo, opnd, zp;
  logic [MemAw-1:0] clr_cnt;
  logic [MemAw-1:0] maddr;
  logic [15:0] a16;
  logic [7:0]  mrd, wdat;
  logic [7:0]  idx;

  // memory port
  always_comb begin
    case (cmd.addr_sel)
      AS_PC:   a16 = wpc;
      AS_IN:   a16 = in_addr;
      AS_EA:   a16 = ea;
      AS_ZP:   a16 = {8'd0, zp};
      AS_ZP1:  a16 = {8'd0, zp + 8'd1};
      default: a16 = 16'd0;
    endcase
    maddr = (cmd.addr_sel == AS_CLR) ? clr_cnt : a16[MemAw-1:0];
  end

  // ALU on operand byte
  logic [8:0] sum;
  logic [7:0] sres, andr, asl_in, asl_r;
  logic [3:0] nflg;
  logic [7:0] nacc;
  logic       take;
  logic [15:0] tgt;

  always_comb begin
    sum    = {1'b0, acc} + {1'b0, opnd} + {8'd0, flg[0]};
    sres   = sum[7:0];
    andr   = acc & opnd;
    asl_in = (cur_mode == M_ACC) ? acc : opnd;
    asl_r  = {asl_in[6:0], 1'b0};
    nflg   = flg;
    nacc   = acc;
    take   = 1'b0;
    case (cur_kind)
      K_ADC: begin
        nacc    = sres;
        nflg[0] = sum[8];
        nflg[2] = (~(acc[7] ^ opnd[7])) & (acc[7] ^ sres[7]);
        nflg[1] = (sres == 8'd0);
        nflg[3] = sres[7];
      end
      K_AND: begin
        nacc    = andr;
        nflg[1] = (andr == 8'd0);
        nflg[3] = andr[7];
      end
      K_ASL: begin
        nflg[0] = asl_in[7];
        nflg[1] = (asl_r == 8'd0);
        nflg[3] = asl_r[7];
        if (cur_mode == M_ACC) nacc = asl_r;
      end
      K_BCC: take = !flg[0];
      K_BCS: take = flg[0];
      K_BEQ: take = flg[1];
      K_BIT: begin
        nflg[1] = (andr == 8'd0);
        nflg[2] = opnd[6];
        nflg[3] = opnd[7];
      end
      default: ;
    endcase
  end

  // branch offset is the byte arriving this cycle
  always_comb begin
    idx  = (cur_mode == M_ABSX) ? xr : (cur_mode == M_ABSY) ? yr : 8'd0;
    tgt  = wpc + {{8{mrd[7]}}, mrd};
    wdat = (cmd.addr_sel == AS_CLR) ? 8'd0 : cmd.wr_asl ? asl_r : in_data;
  end

  ebc_ram #(.Width(8), .Depth(MemDepth)) u_mem (
    .clk   (clk),
    .we    (cmd.mem_we),
    .addr  (maddr),
    .wdata (wdat),
    .re    (cmd.mem_re),
    .rdata (mrd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= 8'd0; xr <= 8'd0; yr <= 8'd0; pc <= 16'd0; flg <= 4'd0;
      clr_cnt <= '0; clr_done <= 1'b0;
      read_data <= 8'd0; cycles_taken <= 3'd0; unsupported <= 1'b0;
    end else begin
      if (!clr_done && cmd.addr_sel == AS_CLR) begin
        clr_cnt <= clr_cnt + 1'b1;
        if (&clr_cnt) clr_done <= 1'b1;
      end
      if (cmd.clr_out) begin
        read_data <= 8'd0; cycles_taken <= 3'd0; unsupported <= 1'b0;
      end
      if (cmd.latch == LT_RD) read_data <= mrd;
      if (cmd.do_load) begin
        acc <= in_data; xr <= in_x; yr <= in_y; pc <= in_addr; flg <= in_flags;
      end
      if (cmd.do_unsup) unsupported <= 1'b1;
      if (cmd.do_exec) begin
        acc <= nacc;
        flg <= nflg;
        pc  <= take ? ea : wpc;
        cycles_taken <= cur_cyc + {2'd0, take};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      in_act <= action; in_addr <= address; in_data <= data;
      in_x <= load_x; in_y <= load_y; in_flags <= load_flags;
      wpc <= pc;
    end
    if (cmd.pc_inc) wpc <= wpc + 16'd1;
    case (cmd.latch)
      LT_OP:   opcode <= mrd;
      LT_LO:   begin lo <= mrd; zp <= mrd + ((cur_mode == M_INDX) ? xr : 8'd0); end
      LT_OPND: opnd <= mrd;
      default: ;
    endcase
    if (cmd.ea_zp)  ea <= {8'd0, mrd + ((cur_mode == M_ZPX) ? xr : 8'd0)};
    // high byte comes straight from the memory port
    if (cmd.ea_abs) begin
      if (cur_mode == M_INDY) ea <= {mrd, lo} + {8'd0, yr};
      else if (cur_mode == M_INDX) ea <= {mrd, lo};
      else ea <= {mrd, lo} + {8'd0, idx};
    end
    if (cmd.ea_rel) ea <= tgt;
    if (cmd.ea_imm) ea <= wpc;
  end

  assign cur_action      = in_act;
  assign program_counter = pc;
  assign accumulator     = acc;
  assign flags           = flg;
endmodule

// ===== hdl/ebc_ctrl.sv =====
// Controller FSM: sequences memory accesses for each action.
// Depends on ebc_pkg.
module ebc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  ebc_pkg::stat_t     stat,
  output ebc_pkg::cmd_t      cmd,
  output logic [2:0]         cur_kind,
  output logic [3:0]         cur_mode,
  output logic [2:0]         cur_cyc
);
  import ebc_pkg::*;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DISP  = 4'd2;
  localparam logic [3:0] S_OPW   = 4'd3;  // opcode in flight
  localparam logic [3:0] S_DEC   = 4'd4;
  localparam logic [3:0] S_B1W   = 4'd5;  // first operand byte in flight
  localparam logic [3:0] S_B2W   = 4'd6;  // high byte in flight
  localparam logic [3:0] S_P0    = 4'd7;  // pointer lo request
  localparam logic [3:0] S_P0W   = 4'd8;
  localparam logic [3:0] S_P1W   = 4'd9;
  localparam logic [3:0] S_MRD   = 4'd10;
  localparam logic [3:0] S_MW    = 4'd11;
  localparam logic [3:0] S_EXEC  = 4'd12;
  localparam logic [3:0] S_RDW   = 4'd13;
  localparam logic [3:0] S_DONE  = 4'd14;

  logic [3:0] state, state_next;
  decode_t    cur, cur_next;

  assign in_stall = (state != S_IDLE) || out_valid;
  assign cur_kind = cur.kind;
  assign cur_mode = cur.mode;
  assign cur_cyc  = cur.cyc;

  always_comb begin
    cmd        = '0;
    state_next = state;
    cur_next   = cur;
    case (state)
      S_CLEAR: begin
        cmd.addr_sel = AS_CLR;
        cmd.mem_we   = 1'b1;
        if (stat.clr_done) begin
          cmd.mem_we = 1'b0;
          state_next = S_IDLE;
        end
      end
      S_IDLE: if (in_valid && !in_stall) begin
        cmd.take_item = 1'b1;
        state_next    = S_DISP;
      end
      S_DISP: begin
        cmd.clr_out = 1'b1;
        case (stat.action)
          ACT_WRITE: begin
            cmd.mem_we = 1'b1; cmd.addr_sel = AS_IN; state_next = S_DONE;
          end
          ACT_READ: begin
            cmd.mem_re = 1'b1; cmd.addr_sel = AS_IN; state_next = S_RDW;
          end
          ACT_LOAD: begin
            cmd.do_load = 1'b1; state_next = S_DONE;
          end
          default: begin
            cmd.mem_re = 1'b1; cmd.addr_sel = AS_PC; cmd.pc_inc = 1'b1;
            state_next = S_OPW;
          end
        endcase
      end
      S_RDW: begin
        cmd.latch = LT_RD; state_next = S_DONE;
      end
      S_OPW: begin
        cmd.latch = LT_OP; state_next = S_DEC;
      end
      S_DEC: begin
        cur_next = stat.dec;
        if (!stat.dec.ok) begin
          cmd.do_unsup = 1'b1; state_next = S_DONE;
        end else if (stat.dec.mode == M_ACC) begin
          state_next = S_EXEC;
        end else if (stat.dec.mode == M_IMM) begin
          cmd.ea_imm = 1'b1; cmd.pc_inc = 1'b1; state_next = S_MRD;
        end else begin
          cmd.mem_re = 1'b1; cmd.addr_sel = AS_PC; cmd.pc_inc = 1'b1;
          state_next = S_B1W;
        end
      end
      S_B1W: begin
        cmd.latch = LT_LO;
        case (cur.mode)
          M_ZP, M_ZPX: begin cmd.ea_zp = 1'b1; state_next = S_MRD; end
          M_REL: begin cmd.ea_rel = 1'b1; state_next = S_EXEC; end
          M_INDX, M_INDY: state_next = S_P0;
          default: begin
            cmd.mem_re = 1'b1; cmd.addr_sel = AS_PC; cmd.pc_inc = 1'b1;
            state_next = S_B2W;
          end
        endcase
      end
      S_B2W: begin
        cmd.ea_abs = 1'b1; state_next = S_MRD;
      end
      S_P0: begin
        cmd.mem_re = 1'b1; cmd.addr_sel = AS_ZP; state_next = S_P0W;
      end
      S_P0W: begin
        // pointer low byte arrives; LT_LO also reloads zp, but this ZP1 request uses the old zp
        cmd.latch = LT_LO;
        cmd.mem_re = 1'b1; cmd.addr_sel = AS_ZP1; state_next = S_P1W;
      end
      S_P1W: begin
        cmd.ea_abs = 1'b1; state_next = S_MRD;
      end
      S_MRD: begin
        cmd.mem_re = 1'b1; cmd.addr_sel = AS_EA; state_next = S_MW;
      end
      S_MW: begin
        cmd.latch = LT_OPND; state_next = S_EXEC;
      end
      S_EXEC: begin
        if (cur.kind == K_ASL && cur.mode != M_ACC) begin
          cmd.mem_we = 1'b1; cmd.wr_asl = 1'b1; cmd.addr_sel = AS_EA;
        end
        cmd.do_exec = 1'b1; state_next = S_DONE;
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR; out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DONE) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
  end
endmodule

// ===== hdl/eight_bit_cpu_instruction_subset_unit.sv =====
// Top level of the eight-bit CPU subset unit: controller plus datapath.
// Depends on ebc_pkg, ebc_ctrl, ebc_datapath (and ebc_ram below it).
//
//  channel | handshake            | payload
//  input   | in_valid / in_stall  | action address data load_x load_y load_flags
//  output  | out_valid / out_stall| program_counter accumulator flags read_data
//          |                      | cycles_taken unsupported
//
// One item at a time; every fetch, pointer and operand access goes through the
// single memory port. After reset a clearing pass zeroes every memory word;
// no item is taken meanwhile. The next item is taken once the result is gone.
module eight_bit_cpu_instruction_subset_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [15:0] address,
  input  logic [7:0]  data,
  input  logic [7:0]  load_x,
  input  logic [7:0]  load_y,
  input  logic [3:0]  load_flags,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] program_counter,
  output logic [7:0]  accumulator,
  output logic [3:0]  flags,
  output logic [7:0]  read_data,
  output logic [2:0]  cycles_taken,
  output logic        unsupported
);
  import ebc_pkg::*;

  cmd_t       cmd;
  stat_t      stat;
  logic [2:0] cur_kind, cur_cyc;
  logic [3:0] cur_mode;
  logic [1:0] cur_action;
  logic [7:0] opcode;
  logic       clr_done;

  assign stat.action   = cur_action;
  assign stat.dec      = decode_op(opcode);
  assign stat.clr_done = clr_done;

  ebc_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall,
    .stat, .cmd, .cur_kind, .cur_mode, .cur_cyc
  );

  ebc_datapath u_dp (
    .clk, .rst, .cmd, .action, .address, .data, .load_x, .load_y, .load_flags,
    .cur_kind, .cur_mode, .cur_cyc, .cur_action, .opcode,
    .program_counter, .accumulator, .flags, .read_data, .cycles_taken,
    .unsupported, .clr_done
  );
endmodule
